// ===== sv/haar_dwt_2d_one_level_unit_assert.svh =====
// Assertion macros for the Haar DWT unit.
`ifndef HAAR_DWT_2D_ONE_LEVEL_UNIT_ASSERT_SVH
`define HAAR_DWT_2D_ONE_LEVEL_UNIT_ASSERT_SVH

`ifndef SYNTH
// expr must never hold outside reset
`define HDWT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
// ante implies cons in the same cycle
`define HDWT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define HDWT_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`define HDWT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/hdwt_pkg.sv =====
`default_nettype none

package hdwt_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int PIXEL_BITS    = 8;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_MIN    = 2;
    localparam int CFG_RESET  = 1024;

    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    // Q0.16 form of 1/sqrt(2)
    localparam int COEF_W    = 16;
    localparam int HAAR_COEF = 46341;
    localparam logic signed [COEF_W:0] COEF_S = (COEF_W + 1)'(HAAR_COEF);

    localparam int HSUM_W = PIXEL_BITS + 1;
    localparam int HL_W   = COEF_W + HSUM_W;
    localparam int HH_W   = COEF_W + HSUM_W;
    localparam int PAIR_W = HL_W + HH_W;
    localparam int VS_W   = HL_W + 2;
    localparam int PROD_W = VS_W + COEF_W + 1;

    localparam int BAND_W     = 13;
    localparam int RND_SHIFT  = 28;
    localparam int ROUND_HALF = 1 << (RND_SHIFT - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // Row-pass result travelling from the row stage to the column stage
    typedef struct packed {
        logic [HL_W-1:0]        hlow;
        logic signed [HH_W-1:0] hhigh;
        logic                   row_odd;
        logic                   last;
    } t_row_item;

    // Q.32 to Q.4, round half up, wrapped to the band width
    function automatic logic [BAND_W-1:0] round_band(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] t;
        t = prod + PROD_W'(ROUND_HALF);
        return t[RND_SHIFT+BAND_W-1:RND_SHIFT];
    endfunction

endpackage

`default_nettype wire

// ===== sv/hdwt_pix_if.sv =====
`default_nettype none

interface hdwt_pix_if import hdwt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== sv/hdwt_coef_if.sv =====
`default_nettype none

interface hdwt_coef_if import hdwt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [BAND_W-1:0]        band_ll;
    logic signed [BAND_W-1:0] band_lh;
    logic signed [BAND_W-1:0] band_hl;
    logic signed [BAND_W-1:0] band_hh;
    logic                     frame_end;

    modport source (output valid, output band_ll, output band_lh, output band_hl,
                    output band_hh, output frame_end, input ready);
    modport sink   (input valid, input band_ll, input band_lh, input band_hl,
                    input band_hh, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== sv/hdwt_ram.sv =====
`default_nettype none

module hdwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/hdwt_row_pass.sv =====
`default_nettype none

module hdwt_row_pass import hdwt_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       i_width,
    input  wire logic [HGT_W-1:0]                     i_height,
    input  wire logic                                 i_s1_take,
    hdwt_pix_if.sink                                  i_pix,
    output logic                                      o_s1_valid,
    output t_row_item                                 o_s1,
    output logic [$clog2(MAX_WIDTH/2)-1:0]            o_s1_idx
);

    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int IDX_W = $clog2(MAX_WIDTH / 2);

    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [PIXEL_BITS-1:0] r_left;
    logic                  r_s1_valid;
    t_row_item             r_s1;
    logic [IDX_W-1:0]      r_s1_idx;

    logic [WID_W-1:0]        w_even;
    logic [HGT_W-1:0]        h_even;
    logic                    active;
    logic                    accept;
    logic                    last;
    logic [HSUM_W-1:0]       hsum;
    logic signed [HSUM_W-1:0] hdiff;
    logic [HL_W-1:0]         hlow;
    logic signed [HH_W-1:0]  hhigh;

    assign w_even = {i_width[WID_W-1:1], 1'b0};
    assign h_even = {i_height[HGT_W-1:1], 1'b0};

    // Only the odd pixel of a pair inside the even-sized window makes a row-pass result
    assign active = r_col[0] && (WID_W'(r_col) < w_even) && (HGT_W'(r_row) < h_even);
    assign last   = (WID_W'(r_col) == w_even - WID_W'(1))
                 && (HGT_W'(r_row) == h_even - HGT_W'(1));

    assign i_pix.ready = !r_s1_valid || i_s1_take || !active;
    assign accept      = i_pix.valid && i_pix.ready;

    assign hsum  = HSUM_W'(r_left) + HSUM_W'(i_pix.pixel);
    assign hdiff = $signed({1'b0, i_pix.pixel}) - $signed({1'b0, r_left});
    assign hlow  = HL_W'(HAAR_COEF) * HL_W'(hsum);
    assign hhigh = HH_W'(COEF_S) * HH_W'(hdiff);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (WID_W'(r_col) + WID_W'(1) >= i_width) begin
                n_col = '0;
                n_row = (HGT_W'(r_row) + HGT_W'(1) >= i_height) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept && !r_col[0]) begin
                r_left <= i_pix.pixel;
            end
            if (accept && active) begin
                r_s1_valid <= 1'b1;
            end else if (i_s1_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && active) begin
            r_s1.hlow    <= hlow;
            r_s1.hhigh   <= hhigh;
            r_s1.row_odd <= r_row[0];
            r_s1.last    <= last;
            r_s1_idx     <= r_col[IDX_W:1];
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_s1_idx   = r_s1_idx;

endmodule

`default_nettype wire

// ===== sv/hdwt_col_pass.sv =====
`default_nettype none

module hdwt_col_pass import hdwt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire t_row_item         i_item,
    input  wire logic [PAIR_W-1:0] i_top_pair,
    output logic                   o_s2_free,
    hdwt_coef_if.source            o_coef
);

    logic                     r_s2_valid;
    logic [HL_W-1:0]          r_s2_hl;
    logic signed [HH_W-1:0]   r_s2_hh;
    logic                     r_s2_last;

    logic                     r_s3_valid;
    logic signed [PROD_W-1:0] r_p_ll, r_p_lh, r_p_hl, r_p_hh;
    logic                     r_s3_last;

    logic                     r_out_valid;
    logic [BAND_W-1:0]        r_ll, r_lh, r_hl, r_hh;
    logic                     r_last;

    logic                     s2_take, s3_take;
    logic [HL_W-1:0]          top_hl;
    logic signed [HH_W-1:0]   top_hh;
    logic signed [VS_W-1:0]   cur_l, cur_h, up_l, up_h;
    logic signed [VS_W-1:0]   s_ll, s_lh, s_hl, s_hh;

    assign s3_take   = r_s3_valid && (!r_out_valid || o_coef.ready);
    assign s2_take   = r_s2_valid && (!r_s3_valid || s3_take);
    assign o_s2_free = !r_s2_valid || s2_take;

    // The store read data lines up with the S2 registers
    assign top_hl = i_top_pair[PAIR_W-1:HH_W];
    assign top_hh = $signed(i_top_pair[HH_W-1:0]);

    assign cur_l = VS_W'($signed({1'b0, r_s2_hl}));
    assign up_l  = VS_W'($signed({1'b0, top_hl}));
    assign cur_h = VS_W'(r_s2_hh);
    assign up_h  = VS_W'(top_hh);

    assign s_ll = up_l + cur_l;
    assign s_lh = cur_l - up_l;
    assign s_hl = up_h + cur_h;
    assign s_hh = cur_h - up_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s2_valid <= 1'b1;
            end else if (s2_take) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_take) begin
                r_s3_valid <= 1'b1;
            end else if (s3_take) begin
                r_s3_valid <= 1'b0;
            end
            if (s3_take) begin
                r_out_valid <= 1'b1;
            end else if (o_coef.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s2_hl   <= i_item.hlow;
            r_s2_hh   <= i_item.hhigh;
            r_s2_last <= i_item.last;
        end
        if (s2_take) begin
            r_p_ll    <= PROD_W'(COEF_S) * PROD_W'(s_ll);
            r_p_lh    <= PROD_W'(COEF_S) * PROD_W'(s_lh);
            r_p_hl    <= PROD_W'(COEF_S) * PROD_W'(s_hl);
            r_p_hh    <= PROD_W'(COEF_S) * PROD_W'(s_hh);
            r_s3_last <= r_s2_last;
        end
        if (s3_take) begin
            r_ll   <= round_band(r_p_ll);
            r_lh   <= round_band(r_p_lh);
            r_hl   <= round_band(r_p_hl);
            r_hh   <= round_band(r_p_hh);
            r_last <= r_s3_last;
        end
    end

    assign o_coef.valid     = r_out_valid;
    assign o_coef.band_ll   = r_ll;
    assign o_coef.band_lh   = $signed(r_lh);
    assign o_coef.band_hl   = $signed(r_hl);
    assign o_coef.band_hh   = $signed(r_hh);
    assign o_coef.frame_end = r_last;

endmodule

`default_nettype wire

// ===== sv/haar_dwt_2d_one_level_unit.sv =====
// One-level 2D Haar DWT on a raster pixel stream, one pixel per clock sustained
// unless the output stalls. Each result for an odd-column pixel of an odd row passes
// the row stage, store read, column multiply and rounding into the output register.
// Throughput: 1 pixel per cycle unless stalled; the line store takes one write or
// one read per cycle. Reset (synchronous, active low) clears counters, left pixel
// and all valid flags; sizes return to 1024x1024. The line store is not cleared.
`default_nettype none

`include "haar_dwt_2d_one_level_unit_assert.svh"

module haar_dwt_2d_one_level_unit import hdwt_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    hdwt_pix_if.sink                  i_pix,
    hdwt_coef_if.source               o_coef
);

    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int IDX_W     = $clog2(MAX_WIDTH / 2);
    localparam int DEPTH     = MAX_WIDTH / 2;
    localparam int WIDTH_RST = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
    localparam int HGT_RST   = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;

    // Sizes are held already clamped to the supported range
    logic [WID_W-1:0] r_width, n_width;
    logic [HGT_W-1:0] r_height, n_height;

    logic              s1_valid;
    t_row_item         s1;
    logic [IDX_W-1:0]  s1_idx;
    logic              s1_take;
    logic              s2_free;
    logic              ram_we, ram_re;
    logic [PAIR_W-1:0] top_pair;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    if (32'(i_cfg_wdata) < CFG_MIN) begin
                        n_width = WID_W'(CFG_MIN);
                    end else if (32'(i_cfg_wdata) > MAX_WIDTH) begin
                        n_width = WID_W'(MAX_WIDTH);
                    end else begin
                        n_width = WID_W'(i_cfg_wdata);
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    if (32'(i_cfg_wdata) < CFG_MIN) begin
                        n_height = HGT_W'(CFG_MIN);
                    end else if (32'(i_cfg_wdata) > MAX_HEIGHT) begin
                        n_height = HGT_W'(MAX_HEIGHT);
                    end else begin
                        n_height = HGT_W'(i_cfg_wdata);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(WIDTH_RST);
            r_height <= HGT_W'(HGT_RST);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    hdwt_row_pass #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_pass (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_s1_take  (s1_take),
        .i_pix      (i_pix),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .o_s1_idx   (s1_idx)
    );

    // Even rows park their pair, odd rows fetch the pair above
    assign s1_take = s1_valid && (!s1.row_odd || s2_free);
    assign ram_we  = s1_take && !s1.row_odd;
    assign ram_re  = s1_take && s1.row_odd;

    hdwt_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s1_idx),
        .i_wdata ({s1.hlow, s1.hhigh}),
        .i_re    (ram_re),
        .i_raddr (s1_idx),
        .o_rdata (top_pair)
    );

    hdwt_col_pass u_col_pass (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ram_re),
        .i_item     (s1),
        .i_top_pair (top_pair),
        .o_s2_free  (s2_free),
        .o_coef     (o_coef)
    );

    `HDWT_ASSERT_NEVER(a_store_one_port, i_clk, i_rst_n, ram_we && ram_re, "store read and write together")
    `HDWT_ASSERT_IMPL(a_take_needs_item, i_clk, i_rst_n, s1_take, s1_valid, "row stage taken while empty")
    `HDWT_ASSERT_IMPL(a_even_row_no_stall, i_clk, i_rst_n, s1_valid && !s1.row_odd, s1_take, "store write stalled")

endmodule

`default_nettype wire

// ===== tb/sv/haar_dwt_2d_one_level_unit_tb.sv =====
`default_nettype none

module haar_dwt_2d_one_level_unit_tb;
    import hdwt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_PIXELS  = 150;

    // pixel patterns for send_frame
    localparam int PAT_UNIFORM = 0;
    localparam int PAT_EXTREME = 1;
    localparam int PAT_NEAR    = 2;

    typedef struct packed {
        logic [BAND_W-1:0] ll;
        logic [BAND_W-1:0] lh;
        logic [BAND_W-1:0] hl;
        logic [BAND_W-1:0] hh;
        logic              frame_end;
    } t_band_set;

    // Predicts the four subbands of every 2x2 block and checks them in order.
    class t_band_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned col;
        int unsigned row;
        logic [PIXEL_BITS-1:0] left_px;
        longint      pair_low[MAX_WIDTH_DEF/2];
        longint      pair_high[MAX_WIDTH_DEF/2];
        t_band_set   band_q[$];
        int          errors;

        function new();
            width_reg  = CFG_RESET;
            height_reg = CFG_RESET;
            col        = 0;
            row        = 0;
            left_px    = '0;
            errors     = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < CFG_MIN) return CFG_MIN;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned frame_pixels();
            return clamp_dim(width_reg, MAX_WIDTH_DEF) * clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        function int pending();
            return band_q.size();
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg = 32'(val);
                CFG_IMAGE_HEIGHT: height_reg = 32'(val);
                default: ;
            endcase
        endfunction

        // Q.32 product to Q.4, round half up, kept to the band width
        function logic [BAND_W-1:0] to_q4(longint v);
            longint t;
            t = (v + (longint'(1) <<< 27)) >>> 28;
            return t[BAND_W-1:0];
        endfunction

        function void note_pixel(logic [PIXEL_BITS-1:0] p);
            int unsigned w, h, we, he, idx;
            longint      hlow, hhigh, tlow, thigh, cf;
            t_band_set   res;
            w  = clamp_dim(width_reg, MAX_WIDTH_DEF);
            h  = clamp_dim(height_reg, MAX_HEIGHT);
            we = w & ~32'd1;
            he = h & ~32'd1;
            cf = longint'(HAAR_COEF);
            if (col[0] == 1'b0) begin
                left_px = p;
            end else if (col < we && row < he) begin
                hlow  = cf * (longint'(left_px) + longint'(p));
                hhigh = cf * (longint'(p) - longint'(left_px));
                idx   = col >> 1;
                if (row[0] == 1'b0) begin
                    pair_low[idx]  = hlow;
                    pair_high[idx] = hhigh;
                end else begin
                    tlow          = pair_low[idx];
                    thigh         = pair_high[idx];
                    res.ll        = to_q4(cf * (tlow + hlow));
                    res.lh        = to_q4(cf * (hlow - tlow));
                    res.hl        = to_q4(cf * (thigh + hhigh));
                    res.hh        = to_q4(cf * (hhigh - thigh));
                    res.frame_end = (col == we - 1) && (row == he - 1);
                    band_q.push_back(res);
                end
            end
            if (col + 1 >= w) begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end else begin
                col = col + 1;
            end
        endfunction

        function void check_field(string name, logic [BAND_W-1:0] exp_v, logic [BAND_W-1:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_coef(t_band_set got);
            t_band_set want;
            if (band_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = band_q.pop_front();
            check_field("band_ll", want.ll, got.ll);
            check_field("band_lh", want.lh, got.lh);
            check_field("band_hl", want.hl, got.hl);
            check_field("band_hh", want.hh, got.hh);
            check_field("frame_end", BAND_W'(want.frame_end), BAND_W'(got.frame_end));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;

    hdwt_pix_if  pix_if();
    hdwt_coef_if coef_if();

    haar_dwt_2d_one_level_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_if.sink),
        .o_coef      (coef_if.source)
    );

    t_band_scoreboard sb = new();
    bit no_idle = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= p;
        do @(posedge i_clk); while (!pix_if.ready);
        sb.note_pixel(p);
    endtask

    // uniform, only 0/255, or small steps around a base level
    task automatic send_frame(input int mode);
        int unsigned n;
        int          base;
        logic [PIXEL_BITS-1:0] p;
        n    = sb.frame_pixels();
        base = $urandom_range(0, 255);
        for (int unsigned i = 0; i < n; i++) begin
            case (mode)
                PAT_EXTREME: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                PAT_NEAR:    p = PIXEL_BITS'(base + $urandom_range(0, 8) - 4);
                default:     p = PIXEL_BITS'($urandom_range(0, 255));
            endcase
            send_pixel(p);
        end
    endtask

    // Stop the pixel stream and let every pending coefficient set come out.
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        i_cfg_wr_en <= 1'b0;
        no_idle = ($urandom_range(0, 3) == 0);
    endtask

    // Output side: random back-pressure, one draw per transaction
    initial begin
        int stall;
        coef_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                coef_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            coef_if.ready <= 1'b1;
            do @(posedge i_clk); while (!coef_if.valid);
            sb.check_coef('{coef_if.band_ll, coef_if.band_lh, coef_if.band_hl,
                            coef_if.band_hh, coef_if.frame_end});
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (coef_if.valid && coef_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [PIXEL_BITS-1:0] blk_4x2[8] = '{8'd0, 8'd0, 8'd255, 8'd0,
                                              8'd0, 8'd0, 8'd0, 8'd255};
        logic [PIXEL_BITS-1:0] odd_3x3[9] = '{8'd0, 8'd255, 8'd7,
                                              8'd255, 8'd0, 8'd128,
                                              8'd1, 8'd2, 8'd3};
        int unsigned random_px;
        int          n_frames;
        logic [CFG_W-1:0] w, h;

        i_rst_n      <= 1'b0;
        i_cfg_wr_en  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_wdata  <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero block and mixed signs
        configure(11'd4, 11'd2);
        foreach (blk_4x2[i]) send_pixel(blk_4x2[i]);
        // sizes below the minimum clamp to 2x2; full-scale block
        configure(11'd0, 11'd1);
        repeat (4) send_pixel(8'hFF);
        // odd width and height: trailing column and row give nothing
        configure(11'd3, 11'd3);
        foreach (odd_3x3[i]) send_pixel(odd_3x3[i]);

        // register values past the top clamp: one full-width row, then shrink
        // the frame so the next row closes it against the stored pair
        configure(11'd2047, 11'd2047);
        repeat (MAX_WIDTH_DEF) send_pixel(PIXEL_BITS'($urandom_range(0, 255)));
        configure(11'd2, 11'd2);
        send_pixel(8'd200);
        send_pixel(8'd17);

        random_px = 0;
        while (random_px < RANDOM_PIXELS) begin
            w = CFG_W'($urandom_range(0, 48));
            h = CFG_W'($urandom_range(0, 14));
            configure(w, h);
            n_frames = $urandom_range(1, 3);
            repeat (n_frames) begin
                send_frame($urandom_range(PAT_UNIFORM, PAT_NEAR));
                random_px += sb.frame_pixels();
            end
        end

        settle();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/hdwt_pkg.sv
sv/hdwt_pix_if.sv
sv/hdwt_coef_if.sv
sv/hdwt_ram.sv
sv/hdwt_row_pass.sv
sv/hdwt_col_pass.sv
sv/haar_dwt_2d_one_level_unit.sv
tb/sv/haar_dwt_2d_one_level_unit_tb.sv
